### rtl/core/trilinear_value_noise_sampler_unit_defines.svh
// assertion helpers for the sampler unit
`ifndef TRILINEAR_VALUE_NOISE_SAMPLER_UNIT_DEFINES_SVH
`define TRILINEAR_VALUE_NOISE_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define TVNS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvns assertion failed");

// next-cycle implication
`define TVNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvns assertion failed");

`endif

### rtl/core/tvns_pkg.sv
package tvns_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W         = 8;
   localparam int VAL_W         = 16;
   localparam int COORD_W       = 32;

   localparam logic [IDX_W-1:0] Y_OFFSET   = 8'd64;
   localparam logic [IDX_W-1:0] Z_OFFSET   = 8'd128;
   localparam logic [IDX_W-1:0] CH2_OFFSET = 8'd16;
   localparam logic [IDX_W-1:0] CH3_OFFSET = 8'd32;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } tvns_op_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [VAL_W-1:0] data;
   } tvns_wr_type;

endpackage

### rtl/core/tvns_table.sv
module tvns_table #(
   parameter int DEPTH = tvns_pkg::TABLE_ENTRIES
) (
   input  logic                           clock,
   input  tvns_pkg::tvns_wr_type          wr,
   input  logic                           rd_en,
   input  logic [tvns_pkg::IDX_W-1:0]     rd_addr,
   output logic [tvns_pkg::VAL_W-1:0]     rd_data_ff
);

   localparam int AW = $clog2(DEPTH);

   logic [tvns_pkg::VAL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

endmodule

### rtl/core/trilinear_value_noise_sampler_unit.sv
// channel | direction | fields
// req     | in        | opcode, entry_index, entry_value, coord_x, coord_y, coord_z
// rsp     | out       | noise_first, noise_second, noise_third
//
// one transaction per cycle while the response is not stalled; the pipeline depth
// is set by two table lookups (corner fetch, hash fetch), the hash sum
// and three blend stages
// table writes give no response; each table copy is written as the write passes its read stage
// synchronous reset clears the valid bits only; the table is undefined until written
// a stalled response freezes the whole pipeline, nothing is dropped or repeated
module trilinear_value_noise_sampler_unit #(
   parameter int FRACTION_BITS = tvns_pkg::FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [tvns_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [tvns_pkg::VAL_W-1:0]        req_entry_value,
   input  logic signed [tvns_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [tvns_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [tvns_pkg::COORD_W-1:0] req_coord_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tvns_pkg::VAL_W-1:0]        rsp_noise_first,
   output logic [tvns_pkg::VAL_W-1:0]        rsp_noise_second,
   output logic [tvns_pkg::VAL_W-1:0]        rsp_noise_third
);

`include "trilinear_value_noise_sampler_unit_defines.svh"

   localparam int IW = tvns_pkg::IDX_W;
   localparam int VW = tvns_pkg::VAL_W;
   localparam int FB = FRACTION_BITS;
   localparam int AW = FB + VW + 1;

   function automatic logic [VW-1:0] lerp(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                          input logic [FB-1:0] t);
      logic [FB:0]   tc;
      logic [AW-1:0] acc;
      tc  = ((FB+1)'(1) << FB) - (FB+1)'(t);
      acc = AW'(a) * AW'(tc) + AW'(b) * AW'(t) + (AW'(1) << (FB-1));
      return acc[FB+VW-1:FB];
   endfunction

   logic en;
   logic accept;

   // stage control: index 1..5 are internal stages
   logic [5:1]  v_ff, v_in;
   logic [5:1]  smp_ff, smp_in;
   logic [IW-1:0] widx1_ff, widx2_ff;
   logic [VW-1:0] wval1_ff, wval2_ff;
   logic [FB-1:0] ax_ff [1:4];
   logic [FB-1:0] ay_ff [1:5];
   logic [FB-1:0] az_ff [1:5];

   logic [IW-1:0] cx, cy, cz;
   logic [IW-1:0] rd1_addr [6];
   logic [VW-1:0] rd1_data [6];
   logic [IW-1:0] hidx_ff [8], hidx_in [8];
   logic [VW-1:0] rd2_data [8][3];
   logic [VW-1:0] xl_ff [3][4], xl_in [3][4];
   logic [VW-1:0] yl_ff [3][2], yl_in [3][2];
   logic [VW-1:0] out_in [3];
   logic [VW-1:0] out_ff [3];
   logic          rsp_valid_ff, rsp_valid_in;

   tvns_pkg::tvns_wr_type wr1, wr2;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;

   assign cx = req_coord_x[FB+IW-1:FB];
   assign cy = req_coord_y[FB+IW-1:FB];
   assign cz = req_coord_z[FB+IW-1:FB];

   assign rd1_addr[0] = cx;
   assign rd1_addr[1] = cx + IW'(1);
   assign rd1_addr[2] = cy + tvns_pkg::Y_OFFSET;
   assign rd1_addr[3] = cy + tvns_pkg::Y_OFFSET + IW'(1);
   assign rd1_addr[4] = cz + tvns_pkg::Z_OFFSET;
   assign rd1_addr[5] = cz + tvns_pkg::Z_OFFSET + IW'(1);

   // corner fetch copies see a write as it is accepted
   always_comb begin
      wr1.en   = accept && (req_opcode == tvns_pkg::OP_WRITE);
      wr1.addr = req_entry_index;
      wr1.data = req_entry_value;
   end

   // hash fetch copies see a write as it leaves stage 2
   always_comb begin
      wr2.en   = en && v_ff[2] && !smp_ff[2];
      wr2.addr = widx2_ff;
      wr2.data = wval2_ff;
   end

   for (genvar r = 0; r < 6; r++) begin : g_rd1
      tvns_table #(.DEPTH(tvns_pkg::TABLE_ENTRIES)) u_tab (
         .clock      (clock),
         .wr         (wr1),
         .rd_en      (en),
         .rd_addr    (rd1_addr[r]),
         .rd_data_ff (rd1_data[r])
      );
   end

   for (genvar k = 0; k < 8; k++) begin : g_corner
      localparam int XS = k % 2;
      localparam int YS = 2 + (k / 2) % 2;
      localparam int ZS = 4 + k / 4;
      logic [VW+1:0] sum;
      assign sum = (VW+2)'(rd1_data[XS]) + (VW+2)'(rd1_data[YS]) + (VW+2)'(rd1_data[ZS]);
      assign hidx_in[k] = sum[15:8];

      for (genvar c = 0; c < 3; c++) begin : g_ch
         logic [IW-1:0] addr;
         assign addr = (c == 0) ? hidx_ff[k] :
                       (c == 1) ? hidx_ff[k] + tvns_pkg::CH2_OFFSET :
                                  hidx_ff[k] + tvns_pkg::CH3_OFFSET;
         tvns_table #(.DEPTH(tvns_pkg::TABLE_ENTRIES)) u_tab (
            .clock      (clock),
            .wr         (wr2),
            .rd_en      (en),
            .rd_addr    (addr),
            .rd_data_ff (rd2_data[k][c])
         );
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int p = 0; p < 4; p++) begin
            xl_in[c][p] = lerp(rd2_data[2*p][c], rd2_data[2*p+1][c], ax_ff[3]);
         end
         yl_in[c][0] = lerp(xl_ff[c][0], xl_ff[c][1], ay_ff[4]);
         yl_in[c][1] = lerp(xl_ff[c][2], xl_ff[c][3], ay_ff[4]);
         out_in[c]   = lerp(yl_ff[c][0], yl_ff[c][1], az_ff[5]);
      end
   end

   always_comb begin
      v_in   = {v_ff[4:1], accept};
      smp_in = {smp_ff[4:1], req_opcode == tvns_pkg::OP_SAMPLE};
      rsp_valid_in = v_ff[5] && smp_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smp_ff   <= smp_in;
         widx1_ff <= req_entry_index;
         wval1_ff <= req_entry_value;
         widx2_ff <= widx1_ff;
         wval2_ff <= wval1_ff;
         ax_ff[1] <= req_coord_x[FB-1:0];
         ay_ff[1] <= req_coord_y[FB-1:0];
         az_ff[1] <= req_coord_z[FB-1:0];
         for (int s = 2; s <= 4; s++) begin
            ax_ff[s] <= ax_ff[s-1];
         end
         for (int s = 2; s <= 5; s++) begin
            ay_ff[s] <= ay_ff[s-1];
            az_ff[s] <= az_ff[s-1];
         end
         hidx_ff <= hidx_in;
         xl_ff   <= xl_in;
         yl_ff   <= yl_in;
         out_ff  <= out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_noise_first  = out_ff[0];
   assign rsp_noise_second = out_ff[1];
   assign rsp_noise_third  = out_ff[2];

   // a frozen pipeline keeps its occupancy
   `TVNS_ASSERT_NEXT(a_stall_hold, clock, reset, !en, v_ff == $past(v_ff))
   // a sample leaving the last internal stage always produces a response
   `TVNS_ASSERT_NEXT(a_sample_out, clock, reset, en && v_ff[5] && smp_ff[5], rsp_valid)
   // table writes never reach the response register
   `TVNS_ASSERT_NEXT(a_write_drop, clock, reset, en && !(v_ff[5] && smp_ff[5]), !rsp_valid)

endmodule
